// ----- design/c8080_pkg.sv -----
// ----------------------------------------------------------------------------
// c8080_pkg
// Types and codes shared by the 8080 subset core.
// ----------------------------------------------------------------------------
`default_nettype none

package c8080_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_CMD, S_F1, S_F2, S_F3, S_A1, S_A2, S_A3, S_EX, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        AS_CMD, AS_PC0, AS_PC1, AS_PC2, AS_ACC1, AS_ACC2
    } t_asel;

    typedef enum logic [2:0] {
        CP_NONE, CP_OP, CP_B1, CP_B2, CP_D1, CP_D2
    } t_cap;

    typedef struct packed {
        logic  load_cmd;
        logic  mem_en;
        logic  mem_we;
        t_asel asel;
        t_cap  cap;
        logic  exec;
        logic  load_resp;
    } t_ctl;

    typedef struct packed {
        t_cmd       cmd;
        logic       run_ok;
        logic [1:0] n_acc;
        logic       acc1_we;
        logic       acc2_we;
    } t_stat;

    // register codes in the opcode fields
    localparam logic [2:0] RC_B = 3'd0;
    localparam logic [2:0] RC_C = 3'd1;
    localparam logic [2:0] RC_D = 3'd2;
    localparam logic [2:0] RC_E = 3'd3;
    localparam logic [2:0] RC_H = 3'd4;
    localparam logic [2:0] RC_L = 3'd5;
    localparam logic [2:0] RC_M = 3'd6;
    localparam logic [2:0] RC_A = 3'd7;

    // opcodes decoded one by one
    localparam logic [7:0] OP_INR_M  = 8'h34;
    localparam logic [7:0] OP_MVI_D  = 8'h16;
    localparam logic [7:0] OP_HLT    = 8'h76;
    localparam logic [7:0] OP_DAD_B  = 8'h09;
    localparam logic [7:0] OP_DAD_D  = 8'h19;
    localparam logic [7:0] OP_DAD_H  = 8'h29;
    localparam logic [7:0] OP_LDAX_B = 8'h0a;
    localparam logic [7:0] OP_LDAX_D = 8'h1a;
    localparam logic [7:0] OP_RRC    = 8'h0f;
    localparam logic [7:0] OP_INX_D  = 8'h13;
    localparam logic [7:0] OP_INX_H  = 8'h23;
    localparam logic [7:0] OP_CMA    = 8'h2f;
    localparam logic [7:0] OP_STA    = 8'h32;
    localparam logic [7:0] OP_LDA    = 8'h3a;
    localparam logic [7:0] OP_ANA_A  = 8'ha7;
    localparam logic [7:0] OP_XRA_A  = 8'haf;
    localparam logic [7:0] OP_POP_B  = 8'hc1;
    localparam logic [7:0] OP_POP_D  = 8'hd1;
    localparam logic [7:0] OP_POP_H  = 8'he1;
    localparam logic [7:0] OP_POP_PSW = 8'hf1;
    localparam logic [7:0] OP_PUSH_B = 8'hc5;
    localparam logic [7:0] OP_PUSH_D = 8'hd5;
    localparam logic [7:0] OP_PUSH_H = 8'he5;
    localparam logic [7:0] OP_PUSH_PSW = 8'hf5;
    localparam logic [7:0] OP_JNZ    = 8'hc2;
    localparam logic [7:0] OP_JZ     = 8'hca;
    localparam logic [7:0] OP_JMP    = 8'hc3;
    localparam logic [7:0] OP_CALL   = 8'hcd;
    localparam logic [7:0] OP_RET    = 8'hc9;
    localparam logic [7:0] OP_ADI    = 8'hc6;
    localparam logic [7:0] OP_ACI    = 8'hce;
    localparam logic [7:0] OP_OUT    = 8'hd3;
    localparam logic [7:0] OP_ANI    = 8'he6;
    localparam logic [7:0] OP_XCHG   = 8'heb;
    localparam logic [7:0] OP_EI     = 8'hfb;
    localparam logic [7:0] OP_CPI    = 8'hfe;

endpackage

`default_nettype wire

// ----- design/c8080_if.sv -----
// ----------------------------------------------------------------------------
// c8080_if
// Command and response channels of the 8080 subset core.
// ----------------------------------------------------------------------------
`default_nettype none

interface c8080_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  write_data;
    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface c8080_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [7:0]  status_word;
    logic        halted;
    logic        fault;
    modport source (output valid, read_data, program_counter, accumulator, status_word,
                    halted, fault, input ready);
    modport sink   (input valid, read_data, program_counter, accumulator, status_word,
                    halted, fault, output ready);
endinterface

`default_nettype wire

// ----- design/c8080_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8080_ctrl
// Sequencer: command decode, instruction fetch, data accesses, response.
// ----------------------------------------------------------------------------
`default_nettype none

module c8080_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  c8080_pkg::t_stat i_stat,
    output c8080_pkg::t_ctl  o_ctl
);
    import c8080_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_ctl.load_resp) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_cmd_valid) n_state = S_CMD;
            S_CMD: begin
                if (i_stat.cmd == CMD_EXEC && i_stat.run_ok) n_state = S_F1;
                else n_state = S_DONE;
            end
            S_F1: n_state = S_F2;
            S_F2: n_state = S_F3;
            S_F3: n_state = (i_stat.n_acc == 2'd0) ? S_EX : S_A1;
            S_A1: n_state = S_A2;
            S_A2: n_state = (i_stat.n_acc == 2'd2) ? S_A3 : S_EX;
            S_A3: n_state = S_EX;
            S_EX: n_state = S_DONE;
            S_DONE: if (slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ctl.asel  = AS_CMD;
        o_ctl.cap   = CP_NONE;
        o_cmd_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd_ready    = 1'b1;
                o_ctl.load_cmd = i_cmd_valid;
            end
            S_CMD: begin
                case (i_stat.cmd)
                    CMD_WRITE: begin
                        o_ctl.mem_en = 1'b1;
                        o_ctl.mem_we = 1'b1;
                    end
                    CMD_READ: o_ctl.mem_en = 1'b1;
                    CMD_EXEC: begin
                        o_ctl.mem_en = i_stat.run_ok;
                        o_ctl.asel   = AS_PC0;
                    end
                    default: o_ctl.mem_en = 1'b0;
                endcase
            end
            S_F1: begin
                o_ctl.mem_en = 1'b1;
                o_ctl.asel   = AS_PC1;
                o_ctl.cap    = CP_OP;
            end
            S_F2: begin
                o_ctl.mem_en = 1'b1;
                o_ctl.asel   = AS_PC2;
                o_ctl.cap    = CP_B1;
            end
            S_F3: o_ctl.cap = CP_B2;
            S_A1: begin
                o_ctl.mem_en = 1'b1;
                o_ctl.mem_we = i_stat.acc1_we;
                o_ctl.asel   = AS_ACC1;
            end
            S_A2: begin
                o_ctl.mem_en = (i_stat.n_acc == 2'd2);
                o_ctl.mem_we = i_stat.acc2_we;
                o_ctl.asel   = AS_ACC2;
                o_ctl.cap    = CP_D1;
            end
            S_A3: o_ctl.cap = CP_D2;
            S_EX: o_ctl.exec = 1'b1;
            S_DONE: o_ctl.load_resp = slot_free;
            default: o_ctl.exec = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ----- design/c8080_dp.sv -----
// ----------------------------------------------------------------------------
// c8080_dp
// Register file, flags, byte memory, instruction decode and execute.
// ----------------------------------------------------------------------------
`default_nettype none

module c8080_dp #(
    parameter int ADDR_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  c8080_pkg::t_ctl  i_ctl,
    output c8080_pkg::t_stat o_stat,
    input  logic [1:0]       i_command,
    input  logic [15:0]      i_address,
    input  logic [7:0]       i_write_data,
    output logic [7:0]       o_read_data,
    output logic [15:0]      o_program_counter,
    output logic [7:0]       o_accumulator,
    output logic [7:0]       o_status_word,
    output logic             o_halted,
    output logic             o_fault
);
    import c8080_pkg::*;

    localparam int MemDepth = 1 << ADDR_BITS;

    // architectural state
    logic [15:0] r_pc, n_pc, r_sp, n_sp;
    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    logic        r_fs, r_fz, r_fac, r_fp, r_fcy;
    logic        n_fs, n_fz, n_fac, n_fp, n_fcy;
    logic        r_halt, n_halt, r_fault, n_fault;

    // command and instruction bytes
    t_cmd        r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [7:0]  r_op, r_b1, r_b2, r_d1, r_d2;

    logic [7:0]  r_mem [0:MemDepth-1];
    logic [7:0]  r_memq;

    logic [7:0]  r_o_rd, r_o_acc, r_o_sw;
    logic [15:0] r_o_pc;
    logic        r_o_halt, r_o_fault;

    logic [2:0]  dst, src;
    logic [1:0]  rp;
    logic [15:0] hl, de, bc, imm, pc3;
    logic [7:0]  psw, dst_v, src_v;

    // access plan
    logic [1:0]  n_acc;
    logic        acc1_we, acc2_we;
    logic [15:0] acc1_addr, acc2_addr, push_v;
    logic [7:0]  acc1_wd, acc2_wd;

    logic [15:0] m_addr16;
    logic [7:0]  m_wd;

    function automatic logic [7:0] f_reg(input logic [2:0] code, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c,
                                         input logic [7:0] d, input logic [7:0] e,
                                         input logic [7:0] h, input logic [7:0] l);
        logic [7:0] v;
        case (code)
            RC_B: v = b;
            RC_C: v = c;
            RC_D: v = d;
            RC_E: v = e;
            RC_H: v = h;
            RC_L: v = l;
            RC_A: v = a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    assign dst = r_op[5:3];
    assign src = r_op[2:0];
    assign rp  = r_op[5:4];
    assign hl  = {r_h, r_l};
    assign de  = {r_d, r_e};
    assign bc  = {r_b, r_c};
    assign imm = {r_b2, r_b1};
    assign pc3 = r_pc + 16'd3;
    assign psw = {r_fs, r_fz, 1'b0, r_fac, 1'b0, r_fp, 1'b1, r_fcy};
    assign dst_v = f_reg(dst, r_a, r_b, r_c, r_d, r_e, r_h, r_l);
    assign src_v = (src == RC_M) ? r_d1 : f_reg(src, r_a, r_b, r_c, r_d, r_e, r_h, r_l);

    always_comb begin
        case (r_op)
            OP_PUSH_B:   push_v = bc;
            OP_PUSH_D:   push_v = de;
            OP_PUSH_H:   push_v = hl;
            OP_PUSH_PSW: push_v = {r_a, psw};
            default:     push_v = pc3;
        endcase
    end

    // memory accesses an instruction needs after its fetch
    always_comb begin
        n_acc     = 2'd0;
        acc1_we   = 1'b0;
        acc2_we   = 1'b0;
        acc1_addr = hl;
        acc2_addr = hl;
        acc1_wd   = r_b1;
        acc2_wd   = r_memq - 8'd1;
        if ((r_op & 8'hc7) == 8'h05 && dst == RC_M) begin
            n_acc   = 2'd2;
            acc2_we = 1'b1;
        end else if ((r_op & 8'hc7) == 8'h06 && dst == RC_M) begin
            n_acc   = 2'd1;
            acc1_we = 1'b1;
        end else if (r_op[7:6] == 2'b01 && r_op != OP_HLT) begin
            if (dst == RC_M) begin
                n_acc   = 2'd1;
                acc1_we = 1'b1;
                acc1_wd = src_v;
            end else if (src == RC_M) begin
                n_acc = 2'd1;
            end
        end else if (r_op[7:4] == 4'h8) begin
            if (src == RC_M) n_acc = 2'd1;
        end else begin
            case (r_op)
                OP_LDAX_B: begin
                    n_acc     = 2'd1;
                    acc1_addr = bc;
                end
                OP_LDAX_D: begin
                    n_acc     = 2'd1;
                    acc1_addr = de;
                end
                OP_LDA: begin
                    n_acc     = 2'd1;
                    acc1_addr = imm;
                end
                OP_STA: begin
                    n_acc     = 2'd1;
                    acc1_we   = 1'b1;
                    acc1_addr = imm;
                    acc1_wd   = r_a;
                end
                OP_POP_B, OP_POP_D, OP_POP_H, OP_POP_PSW, OP_RET: begin
                    n_acc     = 2'd2;
                    acc1_addr = r_sp;
                    acc2_addr = r_sp + 16'd1;
                end
                OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW, OP_CALL: begin
                    n_acc     = 2'd2;
                    acc1_we   = 1'b1;
                    acc2_we   = 1'b1;
                    acc1_addr = r_sp - 16'd1;
                    acc2_addr = r_sp - 16'd2;
                    acc1_wd   = push_v[15:8];
                    acc2_wd   = push_v[7:0];
                end
                default: n_acc = 2'd0;
            endcase
        end
    end

    assign o_stat.cmd     = r_cmd;
    assign o_stat.run_ok  = !r_halt && !r_fault;
    assign o_stat.n_acc   = n_acc;
    assign o_stat.acc1_we = acc1_we;
    assign o_stat.acc2_we = acc2_we;

    // single memory port
    always_comb begin
        m_wd = r_wdata;
        case (i_ctl.asel)
            AS_CMD:  m_addr16 = r_addr;
            AS_PC0:  m_addr16 = r_pc;
            AS_PC1:  m_addr16 = r_pc + 16'd1;
            AS_PC2:  m_addr16 = r_pc + 16'd2;
            AS_ACC1: begin
                m_addr16 = acc1_addr;
                m_wd     = acc1_wd;
            end
            AS_ACC2: begin
                m_addr16 = acc2_addr;
                m_wd     = acc2_wd;
            end
            default: m_addr16 = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_en) begin
            if (i_ctl.mem_we) r_mem[m_addr16[ADDR_BITS-1:0]] <= m_wd;
            else r_memq <= r_mem[m_addr16[ADDR_BITS-1:0]];
        end
    end

    // execute
    always_comb begin
        logic        bad, zsp_en, cy_en, cy_v, rw_en, cin;
        logic [7:0]  zsp_v, rw_v, addend, inc_v;
        logic [8:0]  sum9;
        logic [16:0] sum17;
        logic [15:0] dad_o;
        bad = 1'b0; zsp_en = 1'b0; cy_en = 1'b0; cy_v = 1'b0; rw_en = 1'b0;
        cin = 1'b0; zsp_v = 8'h00; rw_v = 8'h00; addend = src_v; inc_v = 8'h00;
        sum9 = 9'd0; sum17 = 17'd0; dad_o = hl;
        n_pc = r_pc + 16'd1; n_sp = r_sp;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_fs = r_fs; n_fz = r_fz; n_fac = r_fac; n_fp = r_fp; n_fcy = r_fcy;
        n_halt = r_halt; n_fault = r_fault;

        if ((r_op & 8'hc7) == 8'h00) begin
            n_pc = r_pc + 16'd1;
        end else if ((r_op & 8'hcf) == 8'h01) begin
            case (rp)
                2'd0: {n_b, n_c} = imm;
                2'd1: {n_d, n_e} = imm;
                2'd2: {n_h, n_l} = imm;
                default: n_sp = imm;
            endcase
            n_pc = pc3;
        end else if ((r_op & 8'hc7) == 8'h04 && r_op != OP_INR_M) begin
            inc_v  = dst_v + 8'd1;
            rw_en  = 1'b1;
            rw_v   = inc_v;
            zsp_en = 1'b1;
            zsp_v  = inc_v;
        end else if ((r_op & 8'hc7) == 8'h05) begin
            inc_v  = ((dst == RC_M) ? r_d1 : dst_v) - 8'd1;
            rw_en  = (dst != RC_M);
            rw_v   = inc_v;
            zsp_en = 1'b1;
            zsp_v  = inc_v;
        end else if ((r_op & 8'hc7) == 8'h06 && r_op != OP_MVI_D) begin
            rw_en = (dst != RC_M);
            rw_v  = r_b1;
            n_pc  = r_pc + 16'd2;
        end else if (r_op[7:6] == 2'b01 && r_op != OP_HLT) begin
            if (dst == src) bad = 1'b1;
            else begin
                rw_en = (dst != RC_M);
                rw_v  = src_v;
            end
        end else if (r_op[7:4] == 4'h8) begin
            cin    = r_op[3] & r_fcy;
            sum9   = {1'b0, r_a} + {1'b0, src_v} + {8'd0, cin};
            n_a    = sum9[7:0];
            cy_en  = 1'b1;
            cy_v   = sum9[8];
            zsp_en = 1'b1;
            zsp_v  = sum9[7:0];
        end else begin
            case (r_op)
                OP_DAD_B, OP_DAD_D, OP_DAD_H: begin
                    if (r_op == OP_DAD_B) dad_o = bc;
                    else if (r_op == OP_DAD_D) dad_o = de;
                    sum17 = {1'b0, hl} + {1'b0, dad_o};
                    {n_h, n_l} = sum17[15:0];
                    cy_en = 1'b1;
                    cy_v  = sum17[16];
                end
                OP_LDAX_B, OP_LDAX_D: n_a = r_d1;
                OP_LDA: begin
                    n_a  = r_d1;
                    n_pc = pc3;
                end
                OP_RRC: begin
                    cy_en = 1'b1;
                    cy_v  = r_a[0];
                    n_a   = {r_a[0], r_a[7:1]};
                end
                OP_INX_D: {n_d, n_e} = de + 16'd1;
                OP_INX_H: {n_h, n_l} = hl + 16'd1;
                OP_CMA:   n_a = ~r_a;
                OP_STA:   n_pc = pc3;
                OP_HLT:   n_halt = 1'b1;
                OP_ANA_A: begin
                    cy_en  = 1'b1;
                    zsp_en = 1'b1;
                    zsp_v  = r_a;
                end
                OP_XRA_A: begin
                    n_a    = 8'h00;
                    cy_en  = 1'b1;
                    n_fac  = 1'b0;
                    zsp_en = 1'b1;
                end
                OP_POP_B: begin
                    {n_b, n_c} = {r_d2, r_d1};
                    n_sp = r_sp + 16'd2;
                end
                OP_POP_D: begin
                    {n_d, n_e} = {r_d2, r_d1};
                    n_sp = r_sp + 16'd2;
                end
                OP_POP_H: begin
                    {n_h, n_l} = {r_d2, r_d1};
                    n_sp = r_sp + 16'd2;
                end
                OP_POP_PSW: begin
                    n_fs  = r_d1[7];
                    n_fz  = r_d1[6];
                    n_fac = r_d1[4];
                    n_fp  = r_d1[2];
                    n_fcy = r_d1[0];
                    n_a   = r_d2;
                    n_sp  = r_sp + 16'd2;
                end
                OP_PUSH_B, OP_PUSH_D, OP_PUSH_H, OP_PUSH_PSW: n_sp = r_sp - 16'd2;
                OP_JNZ: n_pc = r_fz ? pc3 : imm;
                OP_JZ:  n_pc = r_fz ? imm : pc3;
                OP_JMP: n_pc = imm;
                OP_CALL: begin
                    n_sp = r_sp - 16'd2;
                    n_pc = imm;
                end
                OP_RET: begin
                    n_pc = {r_d2, r_d1};
                    n_sp = r_sp + 16'd2;
                end
                OP_ADI, OP_ACI: begin
                    cin    = (r_op == OP_ACI) & r_fcy;
                    sum9   = {1'b0, r_a} + {1'b0, r_b1} + {8'd0, cin};
                    n_a    = sum9[7:0];
                    cy_en  = 1'b1;
                    cy_v   = sum9[8];
                    zsp_en = 1'b1;
                    zsp_v  = sum9[7:0];
                    n_pc   = r_pc + 16'd2;
                end
                OP_OUT: n_pc = r_pc + 16'd2;
                OP_ANI: begin
                    n_a    = r_a & r_b1;
                    cy_en  = 1'b1;
                    n_fac  = 1'b0;
                    zsp_en = 1'b1;
                    zsp_v  = r_a & r_b1;
                    n_pc   = r_pc + 16'd2;
                end
                OP_XCHG: begin
                    {n_h, n_l} = de;
                    {n_d, n_e} = hl;
                end
                OP_EI: n_pc = r_pc + 16'd1;
                OP_CPI: begin
                    zsp_en = 1'b1;
                    zsp_v  = r_a - r_b1;
                    cy_en  = 1'b1;
                    cy_v   = (r_a < r_b1);
                    n_pc   = r_pc + 16'd2;
                end
                default: bad = 1'b1;
            endcase
        end

        if (rw_en) begin
            case (dst)
                RC_B: n_b = rw_v;
                RC_C: n_c = rw_v;
                RC_D: n_d = rw_v;
                RC_E: n_e = rw_v;
                RC_H: n_h = rw_v;
                RC_L: n_l = rw_v;
                RC_A: n_a = rw_v;
                default: n_a = n_a;
            endcase
        end
        if (zsp_en) begin
            n_fz = (zsp_v == 8'h00);
            n_fs = zsp_v[7];
            n_fp = ~^zsp_v;
        end
        if (cy_en) n_fcy = cy_v;
        if (bad) begin
            n_pc    = r_pc;
            n_fault = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0; r_sp <= '0;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0; r_h <= '0; r_l <= '0;
            r_fs <= 1'b0; r_fz <= 1'b0; r_fac <= 1'b0; r_fp <= 1'b0; r_fcy <= 1'b0;
            r_halt <= 1'b0; r_fault <= 1'b0;
            r_cmd <= CMD_NONE;
        end else begin
            if (i_ctl.load_cmd) r_cmd <= t_cmd'(i_command);
            if (i_ctl.exec) begin
                r_pc <= n_pc; r_sp <= n_sp;
                r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
                r_e <= n_e; r_h <= n_h; r_l <= n_l;
                r_fs <= n_fs; r_fz <= n_fz; r_fac <= n_fac; r_fp <= n_fp; r_fcy <= n_fcy;
                r_halt <= n_halt; r_fault <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_cmd) begin
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
        case (i_ctl.cap)
            CP_OP: r_op <= r_memq;
            CP_B1: r_b1 <= r_memq;
            CP_B2: r_b2 <= r_memq;
            CP_D1: r_d1 <= r_memq;
            CP_D2: r_d2 <= r_memq;
            default: r_op <= r_op;
        endcase
        if (i_ctl.load_resp) begin
            r_o_rd    <= (r_cmd == CMD_READ) ? r_memq : 8'h00;
            r_o_pc    <= r_pc;
            r_o_acc   <= r_a;
            r_o_sw    <= psw;
            r_o_halt  <= r_halt;
            r_o_fault <= r_fault;
        end
    end

    assign o_read_data       = r_o_rd;
    assign o_program_counter = r_o_pc;
    assign o_accumulator     = r_o_acc;
    assign o_status_word     = r_o_sw;
    assign o_halted          = r_o_halt;
    assign o_fault           = r_o_fault;

endmodule

`default_nettype wire

// ----- design/cpu8080_instruction_subset_core.sv -----
// ----------------------------------------------------------------------------
// cpu8080_instruction_subset_core
// 8080 subset core with a byte memory behind a command/response port.
// ----------------------------------------------------------------------------
// Each command takes one transfer in and gives one response transfer out. A
// memory write or read passes through S_CMD and S_DONE before its response is
// registered. An execute does three fetch reads and up to two data accesses
// one after the other on the single memory port, and none when halted or
// faulted. A new command is taken once the previous one has reached the
// response register, which waits while the response is stalled.
`default_nettype none

module cpu8080_instruction_subset_core #(
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8080_cmd_if.sink   i_cmd,
    c8080_rsp_if.source o_rsp
);
    import c8080_pkg::*;

    t_ctl  ctl;
    t_stat stat;

    c8080_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    c8080_dp #(.ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_command         (i_cmd.command),
        .i_address         (i_cmd.address),
        .i_write_data      (i_cmd.write_data),
        .o_read_data       (o_rsp.read_data),
        .o_program_counter (o_rsp.program_counter),
        .o_accumulator     (o_rsp.accumulator),
        .o_status_word     (o_rsp.status_word),
        .o_halted          (o_rsp.halted),
        .o_fault           (o_rsp.fault)
    );

endmodule

`default_nettype wire

// ----- design/c8080_checker.sv -----
// ----------------------------------------------------------------------------
// c8080_checker
// Port-level checks of the 8080 subset core.
// ----------------------------------------------------------------------------
`default_nettype none

module c8080_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_status_word,
    input logic       i_halted
);

    // one command at a time: busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken back to back");

    a_psw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status_word[1] && !i_status_word[3] && !i_status_word[5])
        else $error("bad status word layout");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_halted))
        else $error("stalled response changed");

endmodule

bind cpu8080_instruction_subset_core c8080_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_cmd.valid),
    .i_in_ready    (i_cmd.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_status_word (o_rsp.status_word),
    .i_halted      (o_rsp.halted)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the 8080 subset core: memory writes and reads, and instruction
// execution from programs loaded through the command port, against a
// cycle-free model of the registers, flags and memory.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import c8080_pkg::*;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] program_counter;
        logic [7:0]  accumulator;
        logic [7:0]  status_word;
        logic        halted;
        logic        fault;
    } t_result;

    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    c8080_cmd_if cmd_if ();
    c8080_rsp_if rsp_if ();

    cpu8080_instruction_subset_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    always #6 i_clk = ~i_clk;

    // model state: register file indexed by opcode register codes (M unused)
    logic [7:0]  m_mem [int];
    logic [7:0]  m_reg [8];
    logic [15:0] m_pc, m_sp;
    logic        f_s, f_z, f_ac, f_p, f_cy;
    logic        m_halt, m_fault;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors = 0;

    // host-side view of written bytes, so read commands never target unwritten memory
    bit      written [int];

    function automatic logic [7:0] mem_get(logic [15:0] a);
        return m_mem.exists(a) ? m_mem[a] : 8'h00;
    endfunction

    function automatic logic [15:0] hl();
        return {m_reg[RC_H], m_reg[RC_L]};
    endfunction

    function automatic logic [7:0] operand(logic [2:0] c);
        return (c == RC_M) ? mem_get(hl()) : m_reg[c];
    endfunction

    function automatic void put_operand(logic [2:0] c, logic [7:0] v);
        if (c == RC_M) m_mem[hl()] = v;
        else m_reg[c] = v;
    endfunction

    function automatic void zsp(logic [7:0] v);
        f_z = (v == 8'h00);
        f_s = v[7];
        f_p = ~^v;
    endfunction

    function automatic logic [7:0] psw();
        return {f_s, f_z, 1'b0, f_ac, 1'b0, f_p, 1'b1, f_cy};
    endfunction

    function automatic void push_word(logic [15:0] v);
        m_sp = m_sp - 16'd1;
        m_mem[m_sp] = v[15:8];
        m_sp = m_sp - 16'd1;
        m_mem[m_sp] = v[7:0];
    endfunction

    function automatic logic [15:0] pop_word();
        logic [15:0] w;
        w = {mem_get(m_sp + 16'd1), mem_get(m_sp)};
        m_sp = m_sp + 16'd2;
        return w;
    endfunction

    function automatic void accumulate(logic [7:0] v, logic cin);
        logic [8:0] s;
        s = m_reg[RC_A] + v + cin;
        m_reg[RC_A] = s[7:0];
        f_cy = s[8];
        zsp(s[7:0]);
    endfunction

    function automatic void run_instruction();
        logic [7:0]  op, b1;
        logic [15:0] imm, nxt, t;
        logic [16:0] wide;
        logic [2:0]  dst, src;
        logic [1:0]  rp;
        logic        bad;
        op  = mem_get(m_pc);
        b1  = mem_get(m_pc + 16'd1);
        imm = {mem_get(m_pc + 16'd2), b1};
        nxt = m_pc + 16'd1;
        dst = op[5:3];
        src = op[2:0];
        rp  = op[5:4];
        bad = 1'b0;
        if ((op & 8'hc7) == 8'h00) begin
        end else if ((op & 8'hcf) == 8'h01) begin
            case (rp)
                2'd0: {m_reg[RC_B], m_reg[RC_C]} = imm;
                2'd1: {m_reg[RC_D], m_reg[RC_E]} = imm;
                2'd2: {m_reg[RC_H], m_reg[RC_L]} = imm;
                default: m_sp = imm;
            endcase
            nxt = m_pc + 16'd3;
        end else if ((op & 8'hc7) == 8'h04 && op != OP_INR_M) begin
            put_operand(dst, operand(dst) + 8'd1);
            zsp(operand(dst));
        end else if ((op & 8'hc7) == 8'h05) begin
            put_operand(dst, operand(dst) - 8'd1);
            zsp(operand(dst));
        end else if ((op & 8'hc7) == 8'h06 && op != OP_MVI_D) begin
            put_operand(dst, b1);
            nxt = m_pc + 16'd2;
        end else if (op >= 8'h40 && op <= 8'h7f && op != OP_HLT) begin
            if (dst == src) bad = 1'b1;
            else put_operand(dst, operand(src));
        end else if (op >= 8'h80 && op <= 8'h8f) begin
            accumulate(operand(src), op[3] & f_cy);
        end else begin
            case (op)
                OP_DAD_B, OP_DAD_D, OP_DAD_H: begin
                    t = (op == OP_DAD_B) ? {m_reg[RC_B], m_reg[RC_C]} :
                        (op == OP_DAD_D) ? {m_reg[RC_D], m_reg[RC_E]} : hl();
                    wide = hl() + t;
                    {m_reg[RC_H], m_reg[RC_L]} = wide[15:0];
                    f_cy = wide[16];
                end
                OP_LDAX_B: m_reg[RC_A] = mem_get({m_reg[RC_B], m_reg[RC_C]});
                OP_LDAX_D: m_reg[RC_A] = mem_get({m_reg[RC_D], m_reg[RC_E]});
                OP_RRC: begin
                    f_cy = m_reg[RC_A][0];
                    m_reg[RC_A] = {m_reg[RC_A][0], m_reg[RC_A][7:1]};
                end
                OP_INX_D: {m_reg[RC_D], m_reg[RC_E]} = {m_reg[RC_D], m_reg[RC_E]} + 16'd1;
                OP_INX_H: {m_reg[RC_H], m_reg[RC_L]} = hl() + 16'd1;
                OP_CMA: m_reg[RC_A] = ~m_reg[RC_A];
                OP_STA: begin
                    m_mem[imm] = m_reg[RC_A];
                    nxt = m_pc + 16'd3;
                end
                OP_LDA: begin
                    m_reg[RC_A] = mem_get(imm);
                    nxt = m_pc + 16'd3;
                end
                OP_HLT: m_halt = 1'b1;
                OP_ANA_A: begin
                    f_cy = 1'b0;
                    zsp(m_reg[RC_A]);
                end
                OP_XRA_A: begin
                    m_reg[RC_A] = 8'h00;
                    f_cy = 1'b0;
                    f_ac = 1'b0;
                    zsp(8'h00);
                end
                OP_POP_B: {m_reg[RC_B], m_reg[RC_C]} = pop_word();
                OP_POP_D: {m_reg[RC_D], m_reg[RC_E]} = pop_word();
                OP_POP_H: {m_reg[RC_H], m_reg[RC_L]} = pop_word();
                OP_POP_PSW: begin
                    t = pop_word();
                    {f_s, f_z, f_ac, f_p, f_cy} = {t[7], t[6], t[4], t[2], t[0]};
                    m_reg[RC_A] = t[15:8];
                end
                OP_PUSH_B: push_word({m_reg[RC_B], m_reg[RC_C]});
                OP_PUSH_D: push_word({m_reg[RC_D], m_reg[RC_E]});
                OP_PUSH_H: push_word(hl());
                OP_PUSH_PSW: push_word({m_reg[RC_A], psw()});
                OP_JNZ: nxt = f_z ? m_pc + 16'd3 : imm;
                OP_JZ: nxt = f_z ? imm : m_pc + 16'd3;
                OP_JMP: nxt = imm;
                OP_CALL: begin
                    push_word(m_pc + 16'd3);
                    nxt = imm;
                end
                OP_RET: nxt = pop_word();
                OP_ADI: begin
                    accumulate(b1, 1'b0);
                    nxt = m_pc + 16'd2;
                end
                OP_ACI: begin
                    accumulate(b1, f_cy);
                    nxt = m_pc + 16'd2;
                end
                OP_OUT: nxt = m_pc + 16'd2;
                OP_ANI: begin
                    m_reg[RC_A] = m_reg[RC_A] & b1;
                    f_cy = 1'b0;
                    f_ac = 1'b0;
                    zsp(m_reg[RC_A]);
                    nxt = m_pc + 16'd2;
                end
                OP_XCHG: begin
                    t = hl();
                    {m_reg[RC_H], m_reg[RC_L]} = {m_reg[RC_D], m_reg[RC_E]};
                    {m_reg[RC_D], m_reg[RC_E]} = t;
                end
                OP_EI: ;
                OP_CPI: begin
                    zsp(m_reg[RC_A] - b1);
                    f_cy = m_reg[RC_A] < b1;
                    nxt = m_pc + 16'd2;
                end
                default: bad = 1'b1;
            endcase
        end
        if (bad) m_fault = 1'b1;
        else m_pc = nxt;
    endfunction

    function automatic t_result core_step(t_item it);
        t_result r;
        r.read_data = 8'h00;
        case (t_cmd'(it.command))
            CMD_WRITE: m_mem[it.address] = it.write_data;
            CMD_READ:  r.read_data = mem_get(it.address);
            CMD_EXEC:  if (!m_halt && !m_fault) run_instruction();
            default: ;
        endcase
        r.program_counter = m_pc;
        r.accumulator = m_reg[RC_A];
        r.status_word = psw();
        r.halted = m_halt;
        r.fault = m_fault;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void queue_item(t_cmd c, logic [15:0] a, logic [7:0] d);
        t_item it;
        it.command = c;
        it.address = a;
        it.write_data = d;
        if (c == CMD_WRITE) written[a] = 1;
        pending_items.push_back(it);
    endfunction

    function automatic void poke(logic [15:0] a, logic [7:0] d);
        queue_item(CMD_WRITE, a, d);
    endfunction

    // read back a byte known to be written, else a written-before write
    function automatic void peek(logic [15:0] a);
        if (!written.exists(a)) poke(a, 8'($urandom_range(0, 255)));
        queue_item(CMD_READ, a, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void step_exec(int n);
        repeat (n) queue_item(CMD_EXEC, 16'($urandom), 8'($urandom_range(0, 255)));
    endfunction

    function automatic void load_block(logic [15:0] base, logic [7:0] prog[$]);
        foreach (prog[i]) poke(base + 16'(i), prog[i]);
    endfunction

    // opcodes that leave BC, DE and HL on the filled data page
    function automatic logic [7:0] safe_opcode();
        logic [7:0] pool[$];
        logic [7:0] op;
        pool = '{8'h00, 8'h08, 8'h38, 8'h3c, 8'h3d, 8'h35, OP_LDAX_B,
                 OP_LDAX_D, OP_RRC, OP_CMA, OP_ANA_A, OP_XRA_A, OP_EI,
                 8'h80, 8'h81, 8'h87, 8'h88, 8'h8f, 8'h86, 8'h8e, 8'h78, 8'h7e,
                 8'h77, 8'h70};
        op = pool[$urandom_range(0, pool.size() - 1)];
        return op;
    endfunction

    logic [15:0] data_page;

    // ---------------- driver ----------------
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                expected_results.push_back(core_step(pending_items.pop_front()));
            end
            if (cmd_if.valid && !cmd_if.ready) begin
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                cmd_if.valid <= 1'b1;
                cmd_if.command <= pending_items[0].command;
                cmd_if.address <= pending_items[0].address;
                cmd_if.write_data <= pending_items[0].write_data;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------
    int stall_left = 0;
    int hold_left = 0;
    bit long_hold_armed = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (long_hold_armed && hold_left == 0 && stall_left == 0) begin
            hold_left <= 300;
            long_hold_armed <= 0;
            rsp_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_if.ready <= (hold_left == 1);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 6);
        end
    end

    // ---------------- monitor ----------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n) begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.read_data, rsp_if.program_counter, rsp_if.accumulator,
                       rsp_if.status_word, rsp_if.halted, rsp_if.fault};
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected response %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $display("%0t read_data exp %h got %h", $realtime,
                                 want.read_data, got.read_data);
                        errors++;
                    end
                    if (got.program_counter !== want.program_counter) begin
                        $display("%0t program_counter exp %h got %h", $realtime,
                                 want.program_counter, got.program_counter);
                        errors++;
                    end
                    if (got.accumulator !== want.accumulator) begin
                        $display("%0t accumulator exp %h got %h", $realtime,
                                 want.accumulator, got.accumulator);
                        errors++;
                    end
                    if (got.status_word !== want.status_word) begin
                        $display("%0t status_word exp %h got %h", $realtime,
                                 want.status_word, got.status_word);
                        errors++;
                    end
                    if (got.halted !== want.halted) begin
                        $display("%0t halted exp %b got %b", $realtime,
                                 want.halted, got.halted);
                        errors++;
                    end
                    if (got.fault !== want.fault) begin
                        $display("%0t fault exp %b got %b", $realtime,
                                 want.fault, got.fault);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_NONE;
        cmd_if.address = '0;
        cmd_if.write_data = '0;
        rsp_if.ready = 1'b0;
        foreach (m_reg[i]) m_reg[i] = 8'h00;
        m_pc = '0;
        m_sp = '0;
        {f_s, f_z, f_ac, f_p, f_cy} = '0;
        m_halt = 0;
        m_fault = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: memory extremes, an unknown command, then a small program
        poke(16'h0000, 8'hff);
        poke(16'hffff, 8'h00);
        poke(16'h5aa5, 8'h81);
        peek(16'hffff);
        peek(16'h0000);
        queue_item(CMD_NONE, 16'hffff, 8'hff);
        // at 0: JMP 0100
        poke(16'h0001, 8'h00);
        poke(16'h0002, 8'h01);
        poke(16'h0000, OP_JMP);
        load_block(16'h0100, '{8'h3e, 8'hff, OP_ADI, 8'h01, OP_ACI, 8'h7f,
                               OP_CPI, 8'h80, OP_JZ, 8'h00, 8'h00, OP_JNZ, 8'h10,
                               8'h01, OP_HLT});
        load_block(16'h0110, '{8'h31, 8'h00, 8'h00, OP_CALL, 8'h20, 8'h01, OP_JMP, 8'h00,
                               8'h00});
        load_block(16'h0120, '{OP_PUSH_PSW, OP_POP_D, OP_STA, 8'hf0, 8'h02, OP_LDA,
                               8'hf0, 8'h02, OP_OUT, 8'h00, OP_CMA, OP_XRA_A, OP_RET});
        step_exec(14);
        peek(16'hfffe);
        peek(16'h02f0);
        queue_item(CMD_EXEC, 16'h0, 8'h0);

        // random programs, each reached through the JMP at the hub; all but
        // the last jump back to the hub so the core stays live
        long_hold_armed = 1;
        for (int k = 0; k < 4; k++) begin
            random_live_program(k, k == 3);
            wait (pending_items.size() < 20);
        end
        wait (pending_items.size() == 0 && !cmd_if.valid && expected_results.size() == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // A program that ends with JMP back to a fixed hub, so the core stays live (the
    // last ends in HLT or an unknown opcode). The hub holds a JMP rewritten to each
    // new program start. Each slot gets its own region, so running code is never overwritten.
    task automatic random_live_program(int slot, bit last);
        logic [7:0]  prog[$];
        logic [15:0] base, sp0, hub;
        logic [7:0]  op;
        int          n, steps;
        hub = 16'h0000;
        base = 16'h0400 + 16'(slot) * 16'h0400 + 16'($urandom_range(0, 3)) * 16'h0100;
        data_page = base + 16'h00c0;
        for (int i = 0; i < 32; i++) poke(data_page + 16'(i), 8'($urandom_range(0, 255)));
        sp0 = data_page + 16'd24;
        prog = '{8'h21, data_page[7:0] + 8'd2, data_page[15:8],
                 8'h01, data_page[7:0] + 8'd4, data_page[15:8],
                 8'h11, data_page[7:0] + 8'd6, data_page[15:8],
                 8'h31, sp0[7:0], sp0[15:8],
                 8'h3e, 8'($urandom_range(0, 255))};
        steps = 5;
        n = $urandom_range(6, 14);
        repeat (n) begin
            case ($urandom_range(0, 11))
                0: begin prog.push_back(OP_ADI); prog.push_back(8'($urandom)); end
                1: begin prog.push_back(OP_ACI); prog.push_back(8'($urandom)); end
                2: begin prog.push_back(OP_ANI); prog.push_back(8'($urandom)); end
                3: begin prog.push_back(OP_CPI); prog.push_back(8'($urandom)); end
                4: begin
                    // BC saved around the PSW round trip
                    prog = {prog, OP_PUSH_B, OP_PUSH_PSW, OP_POP_B, OP_PUSH_B, OP_POP_PSW,
                            OP_POP_B};
                    steps += 5;
                end
                5: begin
                    prog = {prog, OP_PUSH_H, OP_XCHG, OP_POP_H, OP_XCHG, OP_INX_D,
                            OP_INX_H};
                    steps += 5;
                end
                6: begin
                    // MVI A or MVI M only: pointer registers stay put
                    prog.push_back($urandom_range(0, 1) ? 8'h3e : 8'h36);
                    prog.push_back(8'($urandom));
                end
                7: begin
                    // skip-over jump with either condition
                    op = $urandom_range(0, 1) ? OP_JZ : OP_JNZ;
                    prog.push_back(op);
                    prog.push_back(base[7:0] + 8'(prog.size()) + 8'd2);
                    prog.push_back(base[15:8]);
                end
                8: begin
                    // INR/DCR and MOV on pointer registers, restored from the stack
                    prog = {prog, OP_PUSH_B, OP_PUSH_D, 8'h04, 8'h0d, 8'h14, 8'h1d,
                            8'h47, 8'h4f, OP_POP_D, OP_POP_B};
                    steps += 9;
                end
                9: begin
                    prog = {prog, OP_PUSH_H, OP_DAD_B, OP_DAD_D, OP_DAD_H, OP_POP_H};
                    steps += 4;
                end
                default: begin
                    op = safe_opcode();
                    prog.push_back(op);
                end
            endcase
            steps++;
        end
        if (last) begin
            prog.push_back($urandom_range(0, 1) ? OP_HLT : 8'hdb);
            steps++;
        end else begin
            prog = {prog, OP_JMP, hub[7:0], hub[15:8]};
            steps++;
        end
        load_block(base, prog);
        poke(hub, OP_JMP);
        poke(hub + 16'd1, base[7:0]);
        poke(hub + 16'd2, base[15:8]);
        // every exec is either inside a loaded program or at the hub
        step_exec(steps + 2);
        repeat ($urandom_range(1, 3)) peek(data_page + 16'($urandom_range(0, 31)));
    endtask

endmodule

`default_nettype wire

// ----- sim.f -----
design/c8080_pkg.sv
design/c8080_if.sv
design/c8080_ctrl.sv
design/c8080_dp.sv
design/cpu8080_instruction_subset_core.sv
design/c8080_checker.sv
tb/testbench.sv
